[rtl/hpt_pkg.sv]
// Shared constants and types of the homogeneous point transform.
package hpt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NUM_REGS        = 8;
    localparam int REG_W           = 64;
    localparam int ADDR_W          = 6;
    localparam int OUT_W           = 32;
    localparam int ENT_W           = 32;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_DIR   = 1'b1;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] hpt_regs_t;

    // Identity matrix with one in Q16.16 on the diagonal.
    localparam hpt_regs_t REG_RESET = {
        64'h0001_0000_0000_0000, 64'h0,
        64'h0000_0000_0001_0000, 64'h0,
        64'h0,                   64'h0001_0000_0000_0000,
        64'h0,                   64'h0000_0000_0001_0000
    };

    // Per-item control that travels alongside the divider lanes.
    typedef struct packed {
        logic                      op_dir;
        logic                      w_zero;
        logic [2:0]                neg;
        logic [2:0]                big;
        logic                      dir_ovf;
        logic [2:0][OUT_W-1:0]     dir_res;
    } hpt_side_t;

endpackage

[rtl/hpt_if.sv]
// Item channels of the homogeneous point transform.
interface hpt_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;

    modport source (output valid, opcode, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, opcode, coord_x, coord_y, coord_z, output ready);
endinterface

interface hpt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic        w_zero;
    logic        overflow;

    modport source (output valid, out_x, out_y, out_z, w_zero, overflow, input ready);
    modport sink   (input valid, out_x, out_y, out_z, w_zero, overflow, output ready);
endinterface

[rtl/hpt_regs.sv]
// APB register file holding the 4x4 transform matrix.
module hpt_regs
    import hpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready,
    output hpt_regs_t         regs
);

    hpt_regs_t matrix_reg;
    logic      wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg <= REG_RESET;
        end
        else if (wr_en)
        begin
            matrix_reg[idx] <= pwdata;
        end
    end

    assign prdata = matrix_reg[idx];
    assign regs   = matrix_reg;

endmodule

[rtl/hpt_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module hpt_div
    import hpt_pkg::*;
#(
    parameter int AW        = 50,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int QB        = COORD_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [AW-1:0] num,
    input  logic [AW-1:0] den,
    output logic [QB-1:0] quot
);

    localparam int NW = AW + FRAC_BITS;

    logic [NW-1:0]    dvd;
    logic [AW+NW-1:0] dvd_ext;

    logic [AW-1:0] rem_reg [QB];
    logic [QB-1:0] low_reg [QB];
    logic [AW-1:0] den_reg [QB];
    logic [QB-1:0] quo_reg [QB];

    assign dvd     = {num, FRAC_BITS'(0)};
    assign dvd_ext = {AW'(0), dvd};

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [AW-1:0] r_in;
        logic [QB-1:0] low_in;
        logic [AW-1:0] d_in;
        logic [QB-1:0] q_in;
        logic [AW:0]   trial;
        logic [AW:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            // Upper dividend bits; below the divisor whenever the quotient fits.
            assign r_in   = dvd_ext[QB +: AW];
            assign low_in = dvd[QB-1:0];
            assign d_in   = den;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign r_in   = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign d_in   = den_reg[k-1];
            assign q_in   = quo_reg[k-1];
        end

        assign trial = {r_in, low_in[QB-1]};
        assign ge    = trial >= {1'b0, d_in};
        assign diff  = trial - {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[AW-1:0] : trial[AW-1:0];
                low_reg[k] <= {low_in[QB-2:0], 1'b0};
                den_reg[k] <= d_in;
                quo_reg[k] <= {q_in[QB-2:0], ge};
            end
        end
    end

    assign quot = quo_reg[QB-1];

endmodule

[rtl/homogeneous_point_transform_core.sv]
// Top level of the homogeneous 4x4 point and direction transform pipeline.
// The block takes one item per clock cycle and returns one result item for every item, in
// order. The restoring divider resolves one quotient bit per pipeline stage for each of
// the x, y and z lanes; ahead of it sit an input register, a stage of twelve products, a
// stage of row sums, and a stage that takes magnitudes, detects zero w and checks in
// advance whether each quotient will saturate. The last stage is the output register. When
// the output item is not taken, every stage holds, so a stall loses and repeats nothing, and
// input ready follows output ready combinationally. The matrix sits in eight 64-bit APB
// registers, row-major, two Q16.16 entries per register, and resets to the identity. It must
// only be rewritten while no item is in flight.
module homogeneous_point_transform_core
    import hpt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    hpt_in_if.sink            in_ch,
    hpt_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready
);

    // Product, shifted product and accumulator widths.
    localparam int PW    = COORD_WIDTH + ENT_W;
    localparam int SW    = PW - FRAC_BITS;
    localparam int AW    = ((SW > ENT_W) ? SW : ENT_W) + 2;
    localparam int NW    = AW + FRAC_BITS;
    localparam int QB    = COORD_WIDTH;
    localparam int CW    = ((NW > AW + COORD_WIDTH) ? NW : AW + COORD_WIDTH) + 1;
    localparam int DEPTH = QB + 5;

    localparam logic signed [AW-1:0]    ACC_MAX = (AW'(1) <<< (COORD_WIDTH - 1)) - AW'(1);
    localparam logic signed [AW-1:0]    ACC_MIN = -ACC_MAX - AW'(1);
    localparam logic signed [OUT_W-1:0] SAT_MAX = (OUT_W'(1) <<< (COORD_WIDTH - 1)) - OUT_W'(1);
    localparam logic signed [OUT_W-1:0] SAT_MIN = -SAT_MAX - OUT_W'(1);

    hpt_regs_t cfg_regs;

    logic                    adv;
    logic [DEPTH-1:0]        v_reg;

    logic signed [ENT_W-1:0] m [4][4];

    logic                         op0_reg;
    logic signed [COORD_WIDTH-1:0] c0_reg [3];

    logic                    op1_reg;
    logic signed [PW-1:0]    prod1_reg [4][3];

    logic                    op2_reg;
    logic signed [AW-1:0]    acc2_reg [4];

    hpt_side_t               side3_next;
    hpt_side_t               side3_reg;
    logic [AW-1:0]           n3_next [3];
    logic [AW-1:0]           n3_reg [3];
    logic [AW-1:0]           d3_next;
    logic [AW-1:0]           d3_reg;

    hpt_side_t               side_reg [QB];
    logic [QB-1:0]           quot [3];

    logic [2:0][OUT_W-1:0]   res_next;
    logic                    ovf_next;
    logic [2:0][OUT_W-1:0]   res_reg;
    logic                    ovf_reg;
    logic                    wz_reg;

    hpt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .regs    (cfg_regs)
    );

    // Matrix entry (r, c) lives in register 2r + c/2, low half for even columns.
    for (genvar r = 0; r < 4; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            assign m[r][c] = cfg_regs[r*2 + c/2][(c%2)*ENT_W +: ENT_W];
        end
    end

    // The whole pipeline moves whenever the output register is free or being emptied.
    assign adv         = !v_reg[DEPTH-1] || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[DEPTH-2:0], in_ch.valid};
        end
    end

    // Input register: only the low COORD_WIDTH bits of each coordinate count.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op0_reg   <= in_ch.opcode;
            c0_reg[0] <= in_ch.coord_x[COORD_WIDTH-1:0];
            c0_reg[1] <= in_ch.coord_y[COORD_WIDTH-1:0];
            c0_reg[2] <= in_ch.coord_z[COORD_WIDTH-1:0];
        end
    end

    // Twelve exact products of coordinate and matrix entry.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg <= op0_reg;
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod1_reg[r][c] <= PW'(c0_reg[c]) * PW'(m[r][c]);
                end
            end
        end
    end

    // Row sums. The arithmetic shift floors each product, and a point adds column three.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op2_reg <= op1_reg;
            for (int r = 0; r < 4; r++)
            begin
                acc2_reg[r] <= ((op1_reg == OP_DIR) ? AW'(0) : AW'(m[r][3]))
                             + AW'(prod1_reg[r][0] >>> FRAC_BITS)
                             + AW'(prod1_reg[r][1] >>> FRAC_BITS)
                             + AW'(prod1_reg[r][2] >>> FRAC_BITS);
            end
        end
    end

    // Magnitudes and signs for the dividers, the zero-w case, and the early saturation
    // check: the quotient exceeds its limit exactly when n * 2^F >= (limit + 1) * d.
    always_comb
    begin
        logic [CW-1:0] lhs;
        logic [CW-1:0] rhs;
        logic          w_neg;

        w_neg               = acc2_reg[3][AW-1];
        d3_next             = w_neg ? AW'(-acc2_reg[3]) : AW'(acc2_reg[3]);
        side3_next          = '0;
        side3_next.op_dir   = (op2_reg == OP_DIR);
        side3_next.w_zero   = (op2_reg == OP_POINT) && (acc2_reg[3] == '0);
        for (int i = 0; i < 3; i++)
        begin
            n3_next[i]            = acc2_reg[i][AW-1] ? AW'(-acc2_reg[i]) : AW'(acc2_reg[i]);
            side3_next.neg[i]     = acc2_reg[i][AW-1] ^ w_neg;
            lhs                   = CW'({n3_next[i], FRAC_BITS'(0)});
            rhs                   = (CW'(d3_next) << (COORD_WIDTH - 1))
                                  + (side3_next.neg[i] ? CW'(d3_next) : CW'(0));
            side3_next.big[i]     = lhs >= rhs;
            if (acc2_reg[i] > ACC_MAX)
            begin
                side3_next.dir_res[i] = SAT_MAX;
                side3_next.dir_ovf    = 1'b1;
            end
            else if (acc2_reg[i] < ACC_MIN)
            begin
                side3_next.dir_res[i] = SAT_MIN;
                side3_next.dir_ovf    = 1'b1;
            end
            else
            begin
                side3_next.dir_res[i] = acc2_reg[i][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side3_reg <= side3_next;
            n3_reg    <= n3_next;
            d3_reg    <= d3_next;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        hpt_div #(
            .AW        (AW),
            .FRAC_BITS (FRAC_BITS),
            .QB        (QB)
        ) u_div (
            .clk  (clk),
            .en   (adv),
            .num  (n3_reg[i]),
            .den  (d3_reg),
            .quot (quot[i])
        );
    end

    // Control travels beside the divider stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side3_reg;
            for (int k = 1; k < QB; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Final selection: direction results, zero w, saturated or signed quotient.
    always_comb
    begin
        hpt_side_t               sd;
        logic [COORD_WIDTH-1:0]  qs;

        sd       = side_reg[QB-1];
        res_next = '0;
        ovf_next = 1'b0;
        qs       = '0;
        if (sd.op_dir)
        begin
            res_next = sd.dir_res;
            ovf_next = sd.dir_ovf;
        end
        else if (!sd.w_zero)
        begin
            for (int i = 0; i < 3; i++)
            begin
                qs = sd.neg[i] ? (~quot[i] + COORD_WIDTH'(1)) : quot[i];
                if (sd.big[i])
                begin
                    res_next[i] = sd.neg[i] ? SAT_MIN : SAT_MAX;
                    ovf_next    = 1'b1;
                end
                else
                begin
                    res_next[i] = OUT_W'($signed(qs));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
            ovf_reg <= ovf_next;
            wz_reg  <= side_reg[QB-1].w_zero;
        end
    end

    assign out_ch.valid    = v_reg[DEPTH-1];
    assign out_ch.out_x    = res_reg[0];
    assign out_ch.out_y    = res_reg[1];
    assign out_ch.out_z    = res_reg[2];
    assign out_ch.w_zero   = wz_reg;
    assign out_ch.overflow = ovf_reg;

    // A zero-w result carries zero coordinates and no overflow.
    a_wzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.w_zero |->
            !out_ch.overflow && out_ch.out_x == '0 && out_ch.out_y == '0
            && out_ch.out_z == '0)
        else $error("zero-w result is not clean");

    // A stall freezes every valid bit.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("pipeline moved during a stall");

    // An item in the last divider stage reaches the output register on an advance.
    a_reach_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv && v_reg[DEPTH-2] |=> out_ch.valid)
        else $error("item lost before the output register");

endmodule

[bench/hpt_result_checker.sv]
// Result checker of the homogeneous point transform: tracks the matrix, predicts and compares.
`timescale 1ns / 1ps

module hpt_result_checker
    import hpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    hpt_in_if                 in_mon,
    hpt_out_if                out_mon,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output int                failures,
    output int                outstanding,
    output int                seen_results,
    output int                seen_w_zero,
    output int                seen_overflow
);

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        w_zero;
        logic        overflow;
    } coord_result_t;

    logic [REG_W-1:0] matrix_regs [NUM_REGS];
    coord_result_t    pending_results [$];

    function automatic longint matrix_entry(int row, int col);
        logic [REG_W-1:0] r;
        logic [31:0]      half;
        r    = matrix_regs[row * 2 + col / 2];
        half = (col % 2) ? r[63:32] : r[31:0];
        return longint'($signed(half));
    endfunction

    // Shift rounds towards minus infinity, which an arithmetic shift gives directly.
    function automatic longint scaled_product(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic logic [31:0] clamp_coord(longint v, inout logic ovf);
        if (v > 64'sd2147483647)
        begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] perspective_divide(longint num, longint den, inout logic ovf);
        logic         neg;
        logic [63:0]  n;
        logic [63:0]  d;
        logic [127:0] q;
        logic [127:0] lim;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? 64'(-num) : 64'(num);
        d   = (den < 0) ? 64'(-den) : 64'(den);
        q   = ({64'b0, n} << 16) / {64'b0, d};
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim)
        begin
            ovf = 1'b1;
            q   = lim;
        end
        return neg ? 32'(-q[31:0]) : q[31:0];
    endfunction

    function automatic coord_result_t transform_coords(logic op, logic [31:0] x, logic [31:0] y,
                                                       logic [31:0] z);
        coord_result_t res;
        longint        c [3];
        longint        acc [4];
        logic          ovf;
        logic [31:0]   lane [3];
        c[0] = longint'($signed(x));
        c[1] = longint'($signed(y));
        c[2] = longint'($signed(z));
        ovf  = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            acc[i] = (op == OP_DIR) ? 0 : matrix_entry(i, 3);
            for (int j = 0; j < 3; j++)
                acc[i] += scaled_product(c[j], matrix_entry(i, j));
        end
        res.w_zero = 1'b0;
        for (int i = 0; i < 3; i++)
            lane[i] = '0;
        if (op == OP_DIR)
        begin
            for (int i = 0; i < 3; i++)
                lane[i] = clamp_coord(acc[i], ovf);
        end
        else if (acc[3] == 0)
            res.w_zero = 1'b1;
        else
        begin
            for (int i = 0; i < 3; i++)
                lane[i] = perspective_divide(acc[i], acc[3], ovf);
        end
        res.x        = lane[0];
        res.y        = lane[1];
        res.z        = lane[2];
        res.overflow = ovf;
        return res;
    endfunction

    assign outstanding = pending_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        coord_result_t exp_res;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                matrix_regs[i] = REG_RESET[i];
            pending_results.delete();
            failures      = 0;
            seen_results  = 0;
            seen_w_zero   = 0;
            seen_overflow = 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                seen_results++;
                if (out_mon.w_zero)
                    seen_w_zero++;
                if (out_mon.overflow)
                    seen_overflow++;
                if (pending_results.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result item x=%h y=%h z=%h", $time,
                             out_mon.out_x, out_mon.out_y, out_mon.out_z);
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (out_mon.out_x !== exp_res.x || out_mon.out_y !== exp_res.y ||
                        out_mon.out_z !== exp_res.z || out_mon.w_zero !== exp_res.w_zero ||
                        out_mon.overflow !== exp_res.overflow)
                    begin
                        failures++;
                        $display("%0t: mismatch expected x=%h y=%h z=%h wz=%b ovf=%b", $time,
                                 exp_res.x, exp_res.y, exp_res.z, exp_res.w_zero,
                                 exp_res.overflow);
                        $display("%0t:          actual   x=%h y=%h z=%h wz=%b ovf=%b", $time,
                                 out_mon.out_x, out_mon.out_y, out_mon.out_z,
                                 out_mon.w_zero, out_mon.overflow);
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
                pending_results.push_back(transform_coords(in_mon.opcode, in_mon.coord_x,
                                                           in_mon.coord_y, in_mon.coord_z));
            // The register index sits above the byte offset within a 64-bit register.
            if (psel && penable && pwrite && pready)
                matrix_regs[paddr[ADDR_W-1:3]] = pwdata;
        end
    end

endmodule

[bench/homogeneous_point_transform_core_tb.sv]
// Testbench top of the homogeneous point transform: stimulus, matrix programming and verdict.
`timescale 1ns / 1ps

module homogeneous_point_transform_core_tb;
    import hpt_pkg::*;

    // Pipeline depth at the default coordinate width, plus some margin.
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [REG_W-1:0]  pwdata;
    logic [REG_W-1:0]  prdata;
    logic              pready;

    int failures;
    int outstanding;
    int seen_results;
    int seen_w_zero;
    int seen_overflow;
    int cycle_count;
    int items_sent;

    // When set, neither side idles, so the pipeline runs at its full rate.
    bit no_gaps;

    hpt_in_if  coord_ch ();
    hpt_out_if result_ch ();

    homogeneous_point_transform_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (coord_ch),
        .out_ch  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hpt_result_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (coord_ch),
        .out_mon       (result_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .failures      (failures),
        .outstanding   (outstanding),
        .seen_results  (seen_results),
        .seen_w_zero   (seen_w_zero),
        .seen_overflow (seen_overflow)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // The whole run is bounded by a cycle count; hitting it is a failure in itself.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
            $display("homogeneous_point_transform_core_tb: done, errors");
            $finish;
        end
    end

    // Result side: before each item it waits a random number of cycles, none if no_gaps is set.
    initial
    begin
        int unsigned hold;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = no_gaps ? 0 : $urandom_range(0, 9);
            result_ch.ready = 1'b0;
            repeat (hold) @(negedge clk);
            result_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
        end
    end

    // Sends one item: optional idle gap, then holds it until the block accepts it.
    // Called just after a falling edge; returns just after the falling edge that follows acceptance.
    task automatic send_item(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            coord_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        coord_ch.valid   = 1'b1;
        coord_ch.opcode  = op;
        coord_ch.coord_x = x;
        coord_ch.coord_y = y;
        coord_ch.coord_z = z;
        do
            @(posedge clk);
        while (!coord_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Lets the pipeline empty before the matrix may be touched.
    task automatic drain_pipeline();
        coord_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // APB write: a setup phase, then an access phase during which the register is taken.
    task automatic write_matrix_reg(int idx, logic [REG_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(idx * 8);
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_matrix(logic [31:0] m [4][4]);
        drain_pipeline();
        for (int r = 0; r < 4; r++)
        begin
            write_matrix_reg(2 * r, {m[r][1], m[r][0]});
            write_matrix_reg(2 * r + 1, {m[r][3], m[r][2]});
        end
    endtask

    // A coordinate that is sometimes fully random, sometimes modest, sometimes an extreme.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2, 3:    return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
            4:       return 32'($urandom_range(0, 32'h0001_FFFF)) - 32'h0001_0000;
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h0001_0000;
                    default: return 32'h0;
                endcase
            end
        endcase
    endfunction

    // Matrix entries mostly stay within a few units so that points land in range.
    function automatic logic [31:0] pick_entry(bit wild);
        if (wild && $urandom_range(0, 2) == 0)
            return $urandom;
        return 32'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
        begin
            // Points dominate, since only they exercise the divider.
            send_item(($urandom_range(0, 3) == 0) ? OP_DIR : OP_POINT,
                      pick_coord(), pick_coord(), pick_coord());
        end
    endtask

    initial
    begin
        logic [31:0] m [4][4];

        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        coord_ch.valid   = 1'b0;
        coord_ch.opcode  = OP_POINT;
        coord_ch.coord_x = '0;
        coord_ch.coord_y = '0;
        coord_ch.coord_z = '0;
        no_gaps          = 1'b0;
        items_sent       = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Identity after reset: zero, the extremes and both operations, which also
        // shows that the identity keeps points unchanged.
        send_item(OP_POINT, 32'h0, 32'h0, 32'h0);
        send_item(OP_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(OP_DIR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        send_item(OP_DIR, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000);
        send_item(OP_POINT, 32'h0001_8000, 32'hFFFE_8000, 32'h0000_0001);

        // Perspective: w equals z, so z of zero gives zero w and small z forces saturation.
        m = '{'{32'h0001_0000, 32'h0, 32'h0, 32'h0},
              '{32'h0, 32'h0001_0000, 32'h0, 32'h0},
              '{32'h0, 32'h0, 32'h0001_0000, 32'h0},
              '{32'h0, 32'h0, 32'h0001_0000, 32'h0}};
        load_matrix(m);
        send_item(OP_POINT, 32'h0005_0000, 32'h0003_0000, 32'h0);
        send_item(OP_DIR, 32'h0005_0000, 32'h0003_0000, 32'h0);
        send_item(OP_POINT, 32'h0005_0000, 32'hFFFD_0000, 32'h0002_0000);
        send_item(OP_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_item(OP_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_POINT, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
        send_item(OP_POINT, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);

        // Extreme entries everywhere: products at their largest, both signs.
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = ((r + c) % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        load_matrix(m);
        send_item(OP_DIR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_DIR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_POINT, 32'h0, 32'h0, 32'h0);
        send_item(OP_POINT, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        run_random(100);

        // A bottom row of zeros: every point has zero w.
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = (r == 3) ? 32'h0 : pick_entry(1'b1);
        load_matrix(m);
        run_random(120);

        // Random matrices, some phases at full rate and some with random idling.
        for (int phase = 0; phase < 8; phase++)
        begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    m[r][c] = pick_entry(phase[0]);
            load_matrix(m);
            no_gaps = (phase % 3 == 1);
            run_random(120);
        end

        // Back to the identity, translation included, and a last burst.
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = (r == c) ? 32'h0001_0000 : ((c == 3) ? pick_entry(1'b0) : 32'h0);
        load_matrix(m);
        no_gaps = 1'b0;
        run_random(60);

        drain_pipeline();
        $display("%0d items sent, %0d results checked, %0d with zero w, %0d saturated",
                 items_sent, seen_results, seen_w_zero, seen_overflow);
        $display("matrices covered: identity, perspective, extreme, zero bottom row, random");
        if (failures == 0 && outstanding == 0)
            $display("homogeneous_point_transform_core_tb: done, clean");
        else
            $display("homogeneous_point_transform_core_tb: done, errors");
        $finish;
    end

endmodule
